@@ hdl/stt_pkg.sv @@
// Shared types, token codes and character class helpers for the source text tokenizer.
package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_IDENT,
        MODE_STRING
    } t_scan_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } t_token;

    typedef struct packed {
        logic [1:0]       count;
        logic [15:0]      line;
        t_token [2:0]     tok;
    } t_bundle;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    localparam logic [4:0] TK_DOT    = 5'd5;
    localparam logic [4:0] TK_BANG   = 5'd12;
    localparam logic [4:0] TK_STRING = 5'd20;
    localparam logic [4:0] TK_NUMBER = 5'd21;
    localparam logic [4:0] TK_IDENT  = 5'd22;
    localparam logic [4:0] TK_VAR    = 5'd23;
    localparam logic [4:0] TK_LOG    = 5'd24;
    localparam logic [4:0] TK_END    = 5'd25;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [3:0] KW_VAR_LEN = 4'd3;
    localparam logic [3:0] KW_LOG_LEN = 4'd12;
    localparam logic [3:0] KW_IDX_MAX = 4'd15;

    // {hit, index}
    function automatic logic [4:0] punct_lookup(input logic [7:0] c);
        case (c)
            8'h28: punct_lookup = {1'b1, 4'd0};
            8'h29: punct_lookup = {1'b1, 4'd1};
            8'h7B: punct_lookup = {1'b1, 4'd2};
            8'h7D: punct_lookup = {1'b1, 4'd3};
            8'h2C: punct_lookup = {1'b1, 4'd4};
            8'h2E: punct_lookup = {1'b1, 4'd5};
            8'h2D: punct_lookup = {1'b1, 4'd6};
            8'h2B: punct_lookup = {1'b1, 4'd7};
            8'h3B: punct_lookup = {1'b1, 4'd8};
            8'h2A: punct_lookup = {1'b1, 4'd9};
            8'h2F: punct_lookup = {1'b1, 4'd10};
            8'h25: punct_lookup = {1'b1, 4'd11};
            default: punct_lookup = 5'd0;
        endcase
    endfunction

    // {hit, index}
    function automatic logic [2:0] op_lookup(input logic [7:0] c);
        case (c)
            8'h21: op_lookup = {1'b1, 2'd0};
            8'h3D: op_lookup = {1'b1, 2'd1};
            8'h3C: op_lookup = {1'b1, 2'd2};
            8'h3E: op_lookup = {1'b1, 2'd3};
            default: op_lookup = 3'd0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                   || (c == 8'h5F);
    endfunction

    function automatic logic [7:0] kw_var_at(input logic [3:0] i);
        case (i)
            4'd0: kw_var_at = 8'h76;
            4'd1: kw_var_at = 8'h61;
            4'd2: kw_var_at = 8'h72;
            default: kw_var_at = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_log_at(input logic [3:0] i);
        case (i)
            4'd0:  kw_log_at = 8'h6C;
            4'd1:  kw_log_at = 8'h6F;
            4'd2:  kw_log_at = 8'h67;
            4'd3:  kw_log_at = 8'h4F;
            4'd4:  kw_log_at = 8'h6E;
            4'd5:  kw_log_at = 8'h43;
            4'd6:  kw_log_at = 8'h6F;
            4'd7:  kw_log_at = 8'h6E;
            4'd8:  kw_log_at = 8'h73;
            4'd9:  kw_log_at = 8'h6F;
            4'd10: kw_log_at = 8'h6C;
            4'd11: kw_log_at = 8'h65;
            default: kw_log_at = 8'h00;
        endcase
    endfunction

endpackage

@@ hdl/stt_if.sv @@
// Valid/ready channel interfaces for source characters and tokens.
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink (input valid, input kind, input char_code, output ready);
endinterface

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start, output token_length,
                    output line_number, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_start, input token_length,
                  input line_number, input last_of_run, output ready);
endinterface

@@ hdl/stt_front.sv @@
// Scanner front end: takes one character per cycle while the queue is not full and builds a bundle of finished tokens.
module stt_front
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stt_in_if.sink        i_src,
    input  logic          i_full,
    output logic          o_push,
    output t_bundle       o_bundle
);

    localparam int SW = OFFSET_BITS + 1;

    function automatic logic [15:0] span(input logic [SW-1:0] e, input logic [SW-1:0] b);
        span = (e >= b) ? 16'(e - b) : 16'd0;
    endfunction

    t_scan_mode             r_mode, n_mode;
    logic [1:0]             r_op, n_op;
    logic [OFFSET_BITS-1:0] r_tb, n_tb;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [15:0]            r_line, n_line;
    logic [3:0]             r_kw_idx, n_kw_idx;
    logic [1:0]             r_kw_alive, n_kw_alive;

    logic [7:0]             c;
    logic                   accept;
    logic [SW-1:0]          p_ext, p1_ext, d_ext, tb_ext;
    logic [OFFSET_BITS-1:0] d;
    logic [4:0]             pl;
    logic [2:0]             ol;
    logic [4:0]             ident_kind;
    logic [3:0]             kt_idx;
    logic [1:0]             kt_alive;
    logic                   f_a, f_b;
    t_token                 f_t0, f_t1;
    logic                   fa, fb, fs, do_start;
    t_token                 t0, t1, t2;

    assign c      = i_src.char_code;
    assign accept = i_src.valid && i_src.ready;
    assign i_src.ready = !i_full;

    assign d      = (r_pos != '0) ? r_pos - 1'b1 : '0;
    assign p_ext  = {1'b0, r_pos};
    assign p1_ext = p_ext + 1'b1;
    assign d_ext  = {1'b0, d};
    assign tb_ext = {1'b0, r_tb};
    assign pl     = punct_lookup(c);
    assign ol     = op_lookup(c);

    always_comb begin
        kt_alive = r_kw_alive;
        if ((r_kw_idx >= KW_VAR_LEN) || (kw_var_at(r_kw_idx) != c)) begin
            kt_alive[0] = 1'b0;
        end
        if ((r_kw_idx >= KW_LOG_LEN) || (kw_log_at(r_kw_idx) != c)) begin
            kt_alive[1] = 1'b0;
        end
        kt_idx = (r_kw_idx < KW_IDX_MAX) ? r_kw_idx + 4'd1 : r_kw_idx;
    end

    always_comb begin
        if (r_kw_alive[0] && (r_kw_idx == KW_VAR_LEN)) begin
            ident_kind = TK_VAR;
        end else if (r_kw_alive[1] && (r_kw_idx == KW_LOG_LEN)) begin
            ident_kind = TK_LOG;
        end else begin
            ident_kind = TK_IDENT;
        end
    end

    // token in progress that ends before the current position
    always_comb begin
        f_a  = 1'b0;
        f_b  = 1'b0;
        f_t0 = '0;
        f_t1 = '0;
        case (r_mode)
            MODE_OP: begin
                f_a  = 1'b1;
                f_t0 = '{kind: TK_BANG + {2'b00, r_op, 1'b0}, start: 16'(r_tb), length: 16'd1};
            end
            MODE_INT, MODE_FRAC: begin
                f_a  = 1'b1;
                f_t0 = '{kind: TK_NUMBER, start: 16'(r_tb), length: span(p_ext, tb_ext)};
            end
            MODE_DOT: begin
                f_a  = 1'b1;
                f_b  = 1'b1;
                f_t0 = '{kind: TK_NUMBER, start: 16'(r_tb), length: span(d_ext, tb_ext)};
                f_t1 = '{kind: TK_DOT, start: 16'(d), length: 16'd1};
            end
            MODE_IDENT: begin
                f_a  = 1'b1;
                f_t0 = '{kind: ident_kind, start: 16'(r_tb), length: span(p_ext, tb_ext)};
            end
            default: begin
                f_a = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_op       = r_op;
        n_tb       = r_tb;
        n_pos      = r_pos;
        n_line     = r_line;
        n_kw_idx   = r_kw_idx;
        n_kw_alive = r_kw_alive;
        fa         = 1'b0;
        fb         = 1'b0;
        fs         = 1'b0;
        t0         = '0;
        t1         = '0;
        t2         = '0;
        do_start   = 1'b0;

        if (i_src.kind) begin
            if (r_mode != MODE_STRING) begin
                fa = f_a;
                fb = f_b;
                t0 = f_t0;
                t1 = f_t1;
            end
            fs         = 1'b1;
            t2         = '{kind: TK_END, start: 16'(r_pos), length: 16'd0};
            n_mode     = MODE_IDLE;
            n_op       = 2'd0;
            n_tb       = '0;
            n_pos      = '0;
            n_line     = 16'd1;
            n_kw_idx   = 4'd0;
            n_kw_alive = 2'b11;
        end else begin
            case (r_mode)
                MODE_OP: begin
                    if (c == CH_EQ) begin
                        fa     = 1'b1;
                        t0     = '{kind: TK_BANG + {2'b00, r_op, 1'b1}, start: 16'(r_tb),
                                   length: span(p1_ext, tb_ext)};
                        n_mode = MODE_IDLE;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (c == CH_DOT) begin
                        n_mode = MODE_DOT;
                    end else if (!is_digit(c)) begin
                        do_start = 1'b1;
                    end
                end
                MODE_DOT: begin
                    if (is_digit(c)) begin
                        n_mode = MODE_FRAC;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (!is_digit(c)) begin
                        do_start = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        n_kw_idx   = kt_idx;
                        n_kw_alive = kt_alive;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        fa     = 1'b1;
                        t0     = '{kind: TK_STRING, start: 16'(r_tb),
                                   length: span(p1_ext, tb_ext)};
                        n_mode = MODE_IDLE;
                    end else if ((c == CH_LF) && (r_line != 16'hFFFF)) begin
                        n_line = r_line + 16'd1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start) begin
                fa     = f_a;
                fb     = f_b;
                t0     = f_t0;
                t1     = f_t1;
                n_mode = MODE_IDLE;
                if (pl[4]) begin
                    fs = 1'b1;
                    t2 = '{kind: {1'b0, pl[3:0]}, start: 16'(r_pos), length: 16'd1};
                end else if (ol[2]) begin
                    n_mode = MODE_OP;
                    n_op   = ol[1:0];
                    n_tb   = r_pos;
                end else if (c == CH_LF) begin
                    if (r_line != 16'hFFFF) begin
                        n_line = r_line + 16'd1;
                    end
                end else if (c == CH_QUOTE) begin
                    n_mode = MODE_STRING;
                    n_tb   = r_pos;
                end else if (is_digit(c)) begin
                    n_mode = MODE_INT;
                    n_tb   = r_pos;
                end else if (is_alpha(c)) begin
                    n_mode     = MODE_IDENT;
                    n_tb       = r_pos;
                    n_kw_idx   = 4'd1;
                    n_kw_alive = {c == kw_log_at(4'd0), c == kw_var_at(4'd0)};
                end
            end

            if (r_pos != '1) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_comb begin
        o_bundle.count  = 2'({1'b0, fa} + {1'b0, fb} + {1'b0, fs});
        o_bundle.line   = r_line;
        o_bundle.tok[0] = fa ? t0 : t2;
        o_bundle.tok[1] = fb ? t1 : t2;
        o_bundle.tok[2] = t2;
        o_push          = accept && (fa || fb || fs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_op       <= 2'd0;
            r_tb       <= '0;
            r_pos      <= '0;
            r_line     <= 16'd1;
            r_kw_idx   <= 4'd0;
            r_kw_alive <= 2'b11;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_op       <= n_op;
            r_tb       <= n_tb;
            r_pos      <= n_pos;
            r_line     <= n_line;
            r_kw_idx   <= n_kw_idx;
            r_kw_alive <= n_kw_alive;
        end
    end

endmodule

@@ hdl/stt_queue.sv @@
// Bundle queue between the scanner and the token serializer.
module stt_queue
    import stt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_head_valid,
    output t_bundle o_head
);

    t_bundle                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  r_wr, r_rd;
    logic [Q_PTR_BITS:0]    r_cnt;
    logic                   pop_ok;

    assign o_full       = (r_cnt == (Q_PTR_BITS + 1)'(Q_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign pop_ok       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hdl/stt_back.sv @@
// Token serializer: sends the tokens of each queued bundle one transfer at a time.
module stt_back
    import stt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  t_bundle       i_head,
    output logic          o_pop,
    stt_out_if.source     o_tok
);

    logic [1:0] r_slot;
    logic       last;
    logic       xfer;
    t_token     cur;

    always_comb begin
        case (r_slot)
            2'd0:    cur = i_head.tok[0];
            2'd1:    cur = i_head.tok[1];
            2'd2:    cur = i_head.tok[2];
            default: cur = i_head.tok[2];
        endcase
    end

    assign last  = (r_slot == (i_head.count - 2'd1));
    assign xfer  = o_tok.valid && o_tok.ready;
    assign o_pop = xfer && last;

    assign o_tok.valid        = i_head_valid;
    assign o_tok.token_kind   = cur.kind;
    assign o_tok.token_start  = cur.start;
    assign o_tok.token_length = cur.length;
    assign o_tok.line_number  = i_head.line;
    assign o_tok.last_of_run  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 2'd0;
        end else if (xfer) begin
            r_slot <= last ? 2'd0 : r_slot + 2'd1;
        end
    end

endmodule

@@ hdl/source_text_tokenizer_unit.sv @@
// Streaming source text tokenizer: characters in, tokens out.
//
// i_src carries one item per transfer: kind 0 is a source byte in char_code,
// kind 1 closes the source. o_tok carries tokens as kind, start offset,
// length and line; last_of_run marks the final token caused by one item.
// The scanner takes one item per cycle unless the queue is full and can emit
// up to three tokens for it (a number, a split-off dot, a punctuation mark;
// or pending tokens, then end). They are queued as one bundle in a four-entry
// queue; the serializer drives one token per cycle from its head while o_tok
// is ready. Latency: a token appears on o_tok in the cycle after the item
// that finishes it is transferred, when no earlier token is waiting.
// Throughput: one item per cycle while the tokens drain at least as fast as
// they are produced; the queue depth and the one-token-per-cycle serializer
// set how long a burst of multi-token items can run before i_src.ready drops.
// When o_tok stalls, the queue fills and i_src.ready falls once it holds
// four bundles. Reset empties the queue and returns the scanner to the start
// of a source at offset 0, line 1; an end item returns the scanner there too.
module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stt_in_if.sink        i_src,
    stt_out_if.source     o_tok
);

    logic    full;
    logic    push;
    t_bundle bundle;
    logic    pop;
    logic    head_valid;
    t_bundle head;

    stt_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src    (i_src),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (bundle)
    );

    stt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_bundle     (bundle),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    stt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_tok        (o_tok)
    );

endmodule
